### src/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when a holds, b holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle assertion failed");

// when a holds, b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle assertion failed");

`endif

### src/scst_pkg.sv
// package: types, sizes and event codes of the shadow call stack tracker
`default_nettype none

package scst_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	localparam logic FUNC_ENTER = 1'b0;
	localparam logic FUNC_EXIT  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ENTER       = 2'd0,
		KIND_EXIT        = 2'd1,
		KIND_CHILD_ENTER = 2'd2,
		KIND_CHILD_EXIT  = 2'd3
	} kind_t;

	typedef struct packed {
		logic        func;
		logic [63:0] routine_addr;
	} item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [63:0] event_addr;
		logic        overflow;
		logic        last;
	} event_t;

endpackage

`default_nettype wire

### src/shadow_call_stack_tracker.sv
// top level: shadow call stack with frame memory and unwind sequencer
//
// usage
//  - input channel: a transaction (item) is taken on a rising edge with start high and
//    busy low. item.func selects routine enter or routine exit.
//  - result channel: each event appears on result for exactly one cycle with strobe
//    high; the receiver cannot stall, so every strobed cycle is one event.
//    result.last marks the final event of an item.
//  - frames sit in a 32 x 64 synchronous memory with one read port and one write
//    port; the sequencer walks it one frame per cycle.
//  - enter: only an enter event on an empty stack, otherwise a child enter, then enter.
//  - exit: frames are searched from the top, then popped from the top down to the
//    match; a child exit for the new top follows unless the stack empties.
//    An exit on an empty stack is taken and dropped.
//  - busy falls on the cycle the last event is strobed, so the next item can be
//    taken then.
//  - reset empties the stack at once; memory contents are left undefined since
//    entries at or above the depth are never read.
`default_nettype none
`include "assert_macros.svh"

module shadow_call_stack_tracker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire scst_pkg::item_t  item,
	output logic                  strobe,
	output scst_pkg::event_t      result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EN_TOP,
		S_EN_PUSH,
		S_SEARCH,
		S_POP,
		S_CHILD_EXIT
	} state_t;

	state_t state_q;

	// frame memory
	logic [63:0] mem [scst_pkg::STACK_DEPTH];
	logic [63:0] rdata_q;
	logic        rd_en;
	logic [scst_pkg::AW-1:0] rd_addr;
	logic        wr_en;

	// item and stack registers
	logic [63:0]              addr_q;
	logic                     ovf_q;
	logic [scst_pkg::DW-1:0]  depth_q;
	logic [scst_pkg::DW-1:0]  depth_m1;
	logic [scst_pkg::AW-1:0]  top;
	logic [scst_pkg::AW-1:0]  ptr_q;
	logic [scst_pkg::AW-1:0]  pos_q;
	logic                     accept;
	logic                     hit;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign depth_m1 = depth_q - scst_pkg::DW'(1);
	assign top      = depth_m1[scst_pkg::AW-1:0];
	assign hit      = (rdata_q == addr_q);
	assign wr_en    = (state_q == S_EN_PUSH) && !ovf_q;

	// read port address: top on accept, then walking down the stack
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = top;
		case (state_q)
			S_IDLE: begin
				rd_en   = accept && (depth_q != '0);
				rd_addr = top;
			end
			S_SEARCH: begin
				rd_en = 1'b1;
				if (hit || (ptr_q == '0)) begin
					rd_addr = top;
				end else begin
					rd_addr = ptr_q - scst_pkg::AW'(1);
				end
			end
			S_POP: begin
				if (ptr_q == pos_q) begin
					rd_en   = (pos_q != '0);
					rd_addr = pos_q - scst_pkg::AW'(1);
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q - scst_pkg::AW'(1);
				end
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = top;
			end
		endcase
	end

	// the push writes at the edge leaving S_EN_PUSH, before any read by the next item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[depth_q[scst_pkg::AW-1:0]] <= addr_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// sequencer with registered events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= item.routine_addr;
						ovf_q  <= (depth_q >= scst_pkg::DW'(scst_pkg::STACK_DEPTH));
						ptr_q  <= top;
						if (item.func == scst_pkg::FUNC_ENTER) begin
							state_q <= (depth_q != '0) ? S_EN_TOP : S_EN_PUSH;
						end else if (depth_q != '0) begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_EN_TOP: begin
					strobe            <= 1'b1;
					result.event_kind <= scst_pkg::KIND_CHILD_ENTER;
					result.event_addr <= rdata_q;
					result.overflow   <= ovf_q;
					result.last       <= 1'b0;
					state_q           <= S_EN_PUSH;
				end
				S_EN_PUSH: begin
					strobe            <= 1'b1;
					result.event_kind <= scst_pkg::KIND_ENTER;
					result.event_addr <= addr_q;
					result.overflow   <= ovf_q;
					result.last       <= 1'b1;
					if (!ovf_q) begin
						depth_q <= depth_q + scst_pkg::DW'(1);
					end
					state_q <= S_IDLE;
				end
				S_SEARCH: begin
					// topmost match wins; restart from the top to pop
					if (hit) begin
						pos_q   <= ptr_q;
						ptr_q   <= top;
						state_q <= S_POP;
					end else if (ptr_q == '0) begin
						state_q <= S_CHILD_EXIT;
					end else begin
						ptr_q <= ptr_q - scst_pkg::AW'(1);
					end
				end
				S_POP: begin
					strobe            <= 1'b1;
					result.event_kind <= scst_pkg::KIND_EXIT;
					result.event_addr <= rdata_q;
					result.overflow   <= 1'b0;
					result.last       <= (ptr_q == pos_q) && (pos_q == '0);
					if (ptr_q == pos_q) begin
						depth_q <= scst_pkg::DW'(pos_q);
						state_q <= (pos_q != '0) ? S_CHILD_EXIT : S_IDLE;
					end else begin
						ptr_q <= ptr_q - scst_pkg::AW'(1);
					end
				end
				S_CHILD_EXIT: begin
					strobe            <= 1'b1;
					result.event_kind <= scst_pkg::KIND_CHILD_EXIT;
					result.event_addr <= rdata_q;
					result.overflow   <= 1'b0;
					result.last       <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// terms used by the checks below
	logic ev_enter_side;
	logic accept_enter;

	assign ev_enter_side = (result.event_kind == scst_pkg::KIND_ENTER) ||
		(result.event_kind == scst_pkg::KIND_CHILD_ENTER);
	assign accept_enter  = accept && (item.func == scst_pkg::FUNC_ENTER);

	// overflow only ever rides on enter-side events
	`ASSERT_SAME(a_ovf_kind, clk, arst_n, strobe && result.overflow, ev_enter_side)
	// depth never exceeds the frame memory
	`ASSERT_SAME(a_depth_bound, clk, arst_n, 1'b1, depth_q <= scst_pkg::DW'(scst_pkg::STACK_DEPTH))
	// an accepted enter always produces work
	`ASSERT_NEXT(a_enter_busy, clk, arst_n, accept_enter, busy)
	// no event can follow the last one of an item directly
	`ASSERT_NEXT(a_last_gap, clk, arst_n, strobe && result.last, !strobe)

endmodule

`default_nettype wire

### verif/shadow_call_stack_tracker_tb.sv
// testbench: shadow call stack tracker checked against a shadow stack predictor
`timescale 1ns / 100ps

module shadow_call_stack_tracker_tb;

	// run length and drain time: room for the worst exit, plus sender gaps
	localparam int RANDOM_ITEMS = 420;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 2 * scst_pkg::STACK_DEPTH + 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	scst_pkg::item_t   item;
	logic              strobe;
	scst_pkg::event_t  result;

	// predictor state: frames of the shadow stack, bottom at index 0
	logic [63:0] shadow_frames [0:scst_pkg::STACK_DEPTH-1];
	int          shadow_depth;

	// events predicted for accepted transactions, oldest first
	scst_pkg::event_t pending_events [$];

	int mismatch_count;
	int cycle_count;

	// sender burst shaping
	int burst_left;

	shadow_call_stack_tracker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop if the design hangs or stops answering
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("shadow_call_stack_tracker test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	function automatic scst_pkg::event_t make_event(input scst_pkg::kind_t kind,
			input logic [63:0] addr, input logic ovf);
		scst_pkg::event_t ev;
		ev.event_kind = kind;
		ev.event_addr = addr;
		ev.overflow   = ovf;
		ev.last       = 1'b0;
		return ev;
	endfunction

	// work out the events of one accepted transaction and advance the shadow stack
	function automatic void predict_stack_events(input scst_pkg::item_t it);
		scst_pkg::event_t evs [$];
		logic             ovf;
		int               pos;
		int               i;
		pos = -1;
		if (it.func == scst_pkg::FUNC_ENTER) begin
			// full stack: both events still go out, flagged, and nothing is pushed
			ovf = (shadow_depth >= scst_pkg::STACK_DEPTH);
			if (shadow_depth > 0)
				evs = {evs, make_event(scst_pkg::KIND_CHILD_ENTER,
					shadow_frames[shadow_depth-1], ovf)};
			if (!ovf) begin
				shadow_frames[shadow_depth] = it.routine_addr;
				shadow_depth++;
			end
			evs = {evs, make_event(scst_pkg::KIND_ENTER, it.routine_addr, ovf)};
		end else if (shadow_depth > 0) begin
			// topmost matching frame wins when an address appears twice
			for (i = shadow_depth - 1; i >= 0; i--) begin
				if (shadow_frames[i] == it.routine_addr) begin
					pos = i;
					break;
				end
			end
			// unwind everything above the match, then the match itself
			if (pos >= 0) begin
				while (shadow_depth > pos) begin
					evs = {evs, make_event(scst_pkg::KIND_EXIT,
						shadow_frames[shadow_depth-1], 1'b0)};
					shadow_depth--;
				end
			end
			// no child exit once the stack has emptied
			if (shadow_depth > 0)
				evs = {evs, make_event(scst_pkg::KIND_CHILD_EXIT,
					shadow_frames[shadow_depth-1], 1'b0)};
		end
		// an exit on an empty stack produces nothing
		if (evs.size() > 0)
			evs[evs.size()-1].last = 1'b1;
		pending_events = {pending_events, evs};
	endfunction

	// one input transaction: optional idle gap at a burst boundary, then hold
	// start high until an edge sees busy low
	task automatic send_call(input logic fn, input logic [63:0] addr);
		scst_pkg::item_t it;
		int              gap;
		it.func         = fn;
		it.routine_addr = addr;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			// about a quarter of bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		// busy read right after the edge is its value at that edge
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_stack_events(it);
		burst_left--;
	endtask

	function automatic logic [63:0] random_addr();
		return {$urandom, $urandom};
	endfunction

	// compare every strobed event with the oldest prediction
	always @(posedge clk) begin : check_events
		scst_pkg::event_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d addr %h",
					result.event_kind, result.event_addr));
			end else begin
				want = pending_events.pop_front();
				if (result.event_kind !== want.event_kind)
					report_mismatch($sformatf("event_kind %0d, want %0d (addr %h)",
						result.event_kind, want.event_kind, want.event_addr));
				if (result.event_addr !== want.event_addr)
					report_mismatch($sformatf("event_addr %h, want %h",
						result.event_addr, want.event_addr));
				if (result.overflow !== want.overflow)
					report_mismatch($sformatf("overflow %b, want %b (addr %h)",
						result.overflow, want.overflow, want.event_addr));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %b, want %b (addr %h)",
						result.last, want.last, want.event_addr));
			end
		end
	end

	// exit on an empty stack right out of reset: taken, no events
	task automatic test_empty_exit();
		send_call(scst_pkg::FUNC_EXIT, 64'h0);
	endtask

	// address extremes, a plain return, an unmatched exit, and an exit that empties
	task automatic test_extremes();
		send_call(scst_pkg::FUNC_ENTER, 64'h0);
		send_call(scst_pkg::FUNC_ENTER, {64{1'b1}});
		send_call(scst_pkg::FUNC_ENTER, 64'h8000_0000_0000_0001);
		send_call(scst_pkg::FUNC_EXIT, 64'h8000_0000_0000_0001);
		send_call(scst_pkg::FUNC_EXIT, 64'h0123_4567_89ab_cdef);
		send_call(scst_pkg::FUNC_EXIT, 64'h0);
	endtask

	// same routine on the stack twice: the upper copy is taken first
	task automatic test_duplicates();
		send_call(scst_pkg::FUNC_ENTER, 64'haaaa_aaaa_aaaa_aaaa);
		send_call(scst_pkg::FUNC_ENTER, 64'h5555_5555_5555_5555);
		send_call(scst_pkg::FUNC_ENTER, 64'haaaa_aaaa_aaaa_aaaa);
		send_call(scst_pkg::FUNC_ENTER, 64'h7fff_ffff_ffff_fffe);
		send_call(scst_pkg::FUNC_EXIT, 64'haaaa_aaaa_aaaa_aaaa);
		send_call(scst_pkg::FUNC_EXIT, 64'haaaa_aaaa_aaaa_aaaa);
	endtask

	// several frames unwound by one exit of the bottom routine
	task automatic test_deep_unwind();
		logic [63:0] bottom;
		bottom = random_addr();
		send_call(scst_pkg::FUNC_ENTER, bottom);
		repeat (4)
			send_call(scst_pkg::FUNC_ENTER, random_addr());
		send_call(scst_pkg::FUNC_EXIT, bottom);
	endtask

	// fill the stack, enter past full, then unwind every frame in one exit
	task automatic test_overflow();
		if (shadow_depth > 0)
			send_call(scst_pkg::FUNC_EXIT, shadow_frames[0]);
		repeat (scst_pkg::STACK_DEPTH)
			send_call(scst_pkg::FUNC_ENTER, random_addr());
		repeat (2)
			send_call(scst_pkg::FUNC_ENTER, random_addr());
		send_call(scst_pkg::FUNC_EXIT, shadow_frames[0]);
		send_call(scst_pkg::FUNC_EXIT, random_addr());
	endtask

	// mostly well-formed call/return traffic in phases of different nesting bias,
	// so the stack drifts between empty and full; some unmatched and stray exits
	task automatic test_random_traffic();
		logic [63:0] addr_pool [0:7];
		logic [63:0] addr;
		logic        fn;
		int          counted;
		int          phase_left;
		int          enter_pct;
		int          roll;
		counted    = 0;
		phase_left = 0;
		enter_pct  = 50;
		addr_pool[0] = 64'h0;
		addr_pool[1] = {64{1'b1}};
		for (int p = 2; p < 8; p++)
			addr_pool[p] = random_addr();
		while (counted < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 60);
				case ($urandom_range(0, 3))
					0: begin
						enter_pct = 25;
					end
					1: begin
						enter_pct = 50;
					end
					2: begin
						enter_pct = 75;
					end
					default: begin
						enter_pct = 95;
					end
				endcase
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < enter_pct) begin
				fn = scst_pkg::FUNC_ENTER;
				if (roll < 55 || shadow_depth == 0)
					addr = random_addr();
				else if (roll < 80)
					addr = shadow_frames[$urandom_range(0, shadow_depth - 1)];
				else
					addr = addr_pool[$urandom_range(0, 7)];
			end else begin
				fn = scst_pkg::FUNC_EXIT;
				if (shadow_depth == 0)
					addr = random_addr();
				else if (roll < 50)
					addr = shadow_frames[shadow_depth - 1];
				else if (roll < 80)
					addr = shadow_frames[$urandom_range(0, shadow_depth - 1)];
				else
					addr = random_addr();
			end
			// exits on an empty stack are dropped by the design, so not counted
			if (fn == scst_pkg::FUNC_ENTER || shadow_depth > 0)
				counted++;
			send_call(fn, addr);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		shadow_depth   = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		burst_left     = 0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_exit();
		test_extremes();
		test_duplicates();
		test_deep_unwind();
		test_overflow();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		// let every predicted event arrive, then watch for stray ones
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_events.size() == 0)
			$display("shadow_call_stack_tracker test passed");
		else
			$display("shadow_call_stack_tracker test failed");
		$finish;
	end

endmodule
